// ===== rtl/tsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsl_pkg: shared definitions for the tempo-synced LFO
// Widths, mode and register codes, walk step sizes and the raised-cosine ROM
// contents, which are built at elaboration time.
// ----------------------------------------------------------------------------
package tsl_pkg;

    localparam int POSITION_FRACTION_BITS = 8;
    localparam int LEVEL_BITS             = 16;
    localparam int COSINE_TABLE_DEPTH     = 256;

    localparam int POSITION_W = 32;
    localparam int RANDOM_W   = 16;
    localparam int LEVEL_W    = LEVEL_BITS + 1;
    localparam int CFG_W      = 2;
    localparam int CFG_IDX_W  = 2;

    // The slowest speed spans 16 quarter notes, so the widest phase has four
    // integer bits above the fraction.
    localparam int PHASE_W = POSITION_FRACTION_BITS + 4;
    localparam int BITS_W  = $clog2(PHASE_W + 1);
    localparam int TBL_W   = $clog2(COSINE_TABLE_DEPTH);
    localparam int ROM_W   = COSINE_TABLE_DEPTH * LEVEL_W;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SELECT = 2'd1;

    // Wave modes.
    localparam logic [1:0] MODE_COSINE = 2'd0;
    localparam logic [1:0] MODE_RAMP   = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;
    localparam logic [1:0] MODE_WALK   = 2'd3;

    // Speeds.
    localparam logic [1:0] SPEED_SLOW   = 2'd0;
    localparam logic [1:0] SPEED_MEDIUM = 2'd1;
    localparam logic [1:0] SPEED_FAST   = 2'd2;
    localparam logic [1:0] SPEED_ULTRA  = 2'd3;
    localparam logic [1:0] SPEED_RESET  = SPEED_FAST;

    localparam logic [RANDOM_W-1:0] RANDOM_HALF = 16'd32768;

    localparam longint unsigned LEVEL_ONE_L = 64'd1 << LEVEL_BITS;

    // Walk steps of 0.001, 0.005, 0.02 and 0.08, rounded to the level grid.
    localparam logic [LEVEL_W-1:0] WALK_STEP_SLOW =
        LEVEL_W'((LEVEL_ONE_L + 64'd500) / 64'd1000);
    localparam logic [LEVEL_W-1:0] WALK_STEP_MEDIUM =
        LEVEL_W'((LEVEL_ONE_L + 64'd100) / 64'd200);
    localparam logic [LEVEL_W-1:0] WALK_STEP_FAST =
        LEVEL_W'((LEVEL_ONE_L + 64'd25) / 64'd50);
    localparam logic [LEVEL_W-1:0] WALK_STEP_ULTRA =
        LEVEL_W'((2 * LEVEL_ONE_L + 64'd12) / 64'd25);

    localparam int RND_UP = (LEVEL_BITS >= RANDOM_W) ? LEVEL_BITS - RANDOM_W : 0;
    localparam int RND_DN = (LEVEL_BITS >= RANDOM_W) ? 0 : RANDOM_W - LEVEL_BITS;

    typedef struct packed {
        logic               trigger;
        logic [LEVEL_W-1:0] ramp;
        logic [LEVEL_W-1:0] cosine;
    } phase_info_t;

    // Random sample, a Q16 fraction, brought onto the level grid.
    function automatic logic [LEVEL_W-1:0] scale_random(input logic [RANDOM_W-1:0] r);
        logic [63:0] t;
        t = 64'(r);
        t = (t << RND_UP) >> RND_DN;
        return t[LEVEL_W-1:0];
    endfunction

    // One raised-cosine entry: a Q30 Taylor series of the cosine folded into
    // the first quadrant, then rounded to the level grid.
    function automatic logic [LEVEL_W-1:0] cos_entry(input int idx);
        longint unsigned q;
        longint unsigned theta;
        longint unsigned t2;
        longint unsigned term;
        longint          sum;
        longint          raised;
        longint unsigned r;
        logic            neg;
        neg = 1'b0;
        q   = 64'(4 * idx);
        if (q > 2 * COSINE_TABLE_DEPTH)
            q = 4 * COSINE_TABLE_DEPTH - q;
        if (q > COSINE_TABLE_DEPTH)
        begin
            q   = 2 * COSINE_TABLE_DEPTH - q;
            neg = 1'b1;
        end
        theta = (64'd3373259426 * q + COSINE_TABLE_DEPTH) / (2 * COSINE_TABLE_DEPTH);
        t2    = (theta * theta) >> 30;
        term  = 64'd1 << 30;
        sum   = 64'sd1 <<< 30;
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * t2) >> 30;
            case (k)
                1: term = term / 64'd2;
                2: term = term / 64'd12;
                3: term = term / 64'd30;
                4: term = term / 64'd56;
                5: term = term / 64'd90;
                6: term = term / 64'd132;
                default: term = term / 64'd182;
            endcase
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > (64'sd1 <<< 30))
            sum = 64'sd1 <<< 30;
        raised = neg ? (64'sd1 <<< 30) - sum : (64'sd1 <<< 30) + sum;
        r = ((unsigned'(raised) << LEVEL_BITS) + (64'd1 << 30)) >> 31;
        return r[LEVEL_W-1:0];
    endfunction

    function automatic logic [ROM_W-1:0] build_cos_rom();
        logic [ROM_W-1:0] rom;
        rom = '0;
        for (int i = 0; i < COSINE_TABLE_DEPTH; i++)
            rom[i*LEVEL_W +: LEVEL_W] = cos_entry(i);
        return rom;
    endfunction

    localparam logic [ROM_W-1:0] COS_ROM = build_cos_rom();

endpackage
`default_nettype wire

// ===== rtl/tsl_phase.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsl_phase: phase extraction
// Slices the phase out of the song position at the selected speed, detects
// the wrap against the previous position, and forms the ramp and the cosine.
// ----------------------------------------------------------------------------
module tsl_phase (
    input  wire logic [1:0]                     speed_select,
    input  wire logic [tsl_pkg::POSITION_W-1:0] song_position,
    input  wire logic [tsl_pkg::POSITION_W-1:0] previous_position,
    output tsl_pkg::phase_info_t                info
);
    import tsl_pkg::*;

    logic [BITS_W-1:0]          phase_bits;
    logic [PHASE_W-1:0]         mask;
    logic [PHASE_W-1:0]         phase;
    logic [PHASE_W-1:0]         prev_phase;
    logic [PHASE_W+TBL_W-1:0]   idx_wide;
    logic [PHASE_W+LEVEL_W-1:0] ramp_wide;
    logic [TBL_W-1:0]           idx;

    always_comb
    begin
        phase_bits = BITS_W'(PHASE_W) - BITS_W'(speed_select);
        mask       = {PHASE_W{1'b1}} >> speed_select;
        phase      = song_position[PHASE_W-1:0] & mask;
        prev_phase = previous_position[PHASE_W-1:0] & mask;
        // Scale the phase fraction onto the table index and the level grid.
        idx_wide   = {phase, {TBL_W{1'b0}}} >> phase_bits;
        ramp_wide  = {1'b0, phase, {LEVEL_BITS{1'b0}}} >> phase_bits;
        idx        = idx_wide[TBL_W-1:0];
        info.trigger = phase < prev_phase;
        info.ramp    = {1'b0, ramp_wide[LEVEL_BITS-1:0]};
        info.cosine  = COS_ROM[idx*LEVEL_W +: LEVEL_W];
    end

endmodule
`default_nettype wire

// ===== rtl/tsl_level.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsl_level: level generator
// Holds the shared level and updates it once per transaction according to
// the wave mode: cosine, ramp, sample-and-hold or reflecting random walk.
// ----------------------------------------------------------------------------
module tsl_level (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic [1:0]                   wave_mode,
    input  wire logic [1:0]                   speed_select,
    input  wire logic [tsl_pkg::RANDOM_W-1:0] random_sample,
    input  wire tsl_pkg::phase_info_t         info,
    output logic [tsl_pkg::LEVEL_W-1:0]       level_next
);
    import tsl_pkg::*;

    localparam logic signed [LEVEL_W+1:0] ONE_S = (LEVEL_W+2)'(LEVEL_ONE_L);
    localparam logic signed [LEVEL_W+1:0] TWO_S = (LEVEL_W+2)'(2 * LEVEL_ONE_L);

    logic [LEVEL_W-1:0]        held_level_reg;
    logic [LEVEL_W-1:0]        step;
    logic signed [LEVEL_W+1:0] walk;

    always_comb
    begin
        case (speed_select)
            SPEED_SLOW:   step = WALK_STEP_SLOW;
            SPEED_MEDIUM: step = WALK_STEP_MEDIUM;
            SPEED_FAST:   step = WALK_STEP_FAST;
            default:      step = WALK_STEP_ULTRA;
        endcase

        // Step up or down, then fold back into the unit interval.
        if (random_sample > RANDOM_HALF)
            walk = $signed({2'b00, held_level_reg}) + $signed({2'b00, step});
        else
            walk = $signed({2'b00, held_level_reg}) - $signed({2'b00, step});
        if (walk > ONE_S)
            walk = TWO_S - walk;
        else if (walk < 0)
            walk = -walk;

        unique case (wave_mode)
            MODE_COSINE: level_next = info.cosine;
            MODE_RAMP:   level_next = info.ramp;
            MODE_SAMPLE: level_next = info.trigger ? scale_random(random_sample)
                                                   : held_level_reg;
            default:     level_next = walk[LEVEL_W-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_level_reg <= '0;
        else if (advance)
            held_level_reg <= level_next;
    end

endmodule
`default_nettype wire

// ===== rtl/tempo_synced_lfo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tempo_synced_lfo: tempo-synced low frequency oscillator
// Turns a stream of song positions and random samples into modulation levels.
// ----------------------------------------------------------------------------
// Usage. Each input transaction on in_valid/in_ready carries a song position
// in quarter notes (Q24.8) and a 16-bit random sample. Each one produces
// exactly one output transaction on out_valid/out_ready carrying the level
// and the raised cosine at the current phase, both Q16 with 65536 as 1.0.
// The configuration port writes wave_mode (index 0) and speed_select
// (index 1) on any cycle with cfg_write high; other indexes are ignored.
// Configuration should only change while no transaction is in flight.
// Each transaction passes through the input register and then the result
// register. Throughput is one transaction per cycle while out_ready stays high,
// set by the single pass of phase slicing, cosine ROM lookup and walk add between them.
// When the receiver stalls, the result register holds its transaction and
// the input register can still take one more; after that in_ready drops.
// Reset clears both valid flags, the previous position and the held level,
// and sets wave_mode to cosine and speed_select to fast.
// ----------------------------------------------------------------------------
module tempo_synced_lfo (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [tsl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tsl_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [tsl_pkg::POSITION_W-1:0]   song_position,
    input  wire logic [tsl_pkg::RANDOM_W-1:0]     random_sample,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [tsl_pkg::LEVEL_W-1:0]           level,
    output logic [tsl_pkg::LEVEL_W-1:0]           cosine_level
);
    import tsl_pkg::*;

    logic [1:0]            wave_mode_reg;
    logic [1:0]            speed_select_reg;
    logic                  inp_valid_reg;
    logic [POSITION_W-1:0] inp_position_reg;
    logic [RANDOM_W-1:0]   inp_random_reg;
    logic [POSITION_W-1:0] previous_position_reg;
    logic                  out_valid_reg;
    logic [LEVEL_W-1:0]    level_reg;
    logic [LEVEL_W-1:0]    cosine_reg;
    logic                  advance;
    logic [LEVEL_W-1:0]    level_next;
    phase_info_t           info;

    // The item in the input register moves on whenever the result register
    // is empty or is being emptied in this cycle.
    assign advance  = inp_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !inp_valid_reg || advance;

    assign out_valid    = out_valid_reg;
    assign level        = level_reg;
    assign cosine_level = cosine_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg    <= MODE_COSINE;
            speed_select_reg <= SPEED_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WAVE_MODE:    wave_mode_reg    <= cfg_data;
                REG_SPEED_SELECT: speed_select_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inp_valid_reg <= 1'b0;
        else if (in_ready)
            inp_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            inp_position_reg <= song_position;
            inp_random_reg   <= random_sample;
        end
    end

    // The previous position feeds wrap detection for sample-and-hold.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            previous_position_reg <= '0;
        else if (advance)
            previous_position_reg <= inp_position_reg;
    end

    tsl_phase u_phase (
        .speed_select      (speed_select_reg),
        .song_position     (inp_position_reg),
        .previous_position (previous_position_reg),
        .info              (info)
    );

    tsl_level u_level (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .wave_mode     (wave_mode_reg),
        .speed_select  (speed_select_reg),
        .random_sample (inp_random_reg),
        .info          (info),
        .level_next    (level_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || out_ready)
            out_valid_reg <= inp_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            level_reg  <= level_next;
            cosine_reg <= info.cosine;
        end
    end

endmodule
`default_nettype wire

// ===== tb/lfo_level_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_level_checker: result predictor and comparator for the tempo-synced LFO
// Watches the register port and both handshakes, predicts each level and
// raised cosine, and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module lfo_level_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [tsl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tsl_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                             in_valid,
    input  wire logic                             in_ready,
    input  wire logic [tsl_pkg::POSITION_W-1:0]   song_position,
    input  wire logic [tsl_pkg::RANDOM_W-1:0]     random_sample,
    input  wire logic                             out_valid,
    input  wire logic                             out_ready,
    input  wire logic [tsl_pkg::LEVEL_W-1:0]      level,
    input  wire logic [tsl_pkg::LEVEL_W-1:0]      cosine_level,
    output int                                    mismatches,
    output int                                    in_flight,
    output int                                    results_seen
);
    import tsl_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] cosine;
    } lfo_sample_t;

    localparam longint unsigned ONE_Q30      = 64'd1 << 30;
    localparam longint unsigned PI_Q30       = 64'd3373259426;
    localparam int              REPORT_LIMIT = 10;

    logic [CFG_W-1:0]      mode_q;
    logic [CFG_W-1:0]      speed_q;
    logic [POSITION_W-1:0] last_position;
    logic [LEVEL_W-1:0]    held_level_q;
    logic [LEVEL_W-1:0]    cosine_table [COSINE_TABLE_DEPTH];
    lfo_sample_t           expected_levels [$];
    lfo_sample_t           oldest;

    // Raised cosine at idx / depth: the angle is folded into the first
    // quadrant and the cosine summed as a Q30 Taylor series.
    function automatic logic [LEVEL_W-1:0] raised_cosine(input int unsigned idx);
        longint unsigned depth;
        longint unsigned quarter;
        longint unsigned angle;
        longint unsigned angle_sq;
        longint unsigned term;
        longint unsigned scaled;
        longint          series;
        longint          raised;
        bit              negative;
        int              k;
        depth    = COSINE_TABLE_DEPTH;
        quarter  = 4 * (idx % depth);
        negative = 1'b0;
        if (quarter > 2 * depth)
            quarter = 4 * depth - quarter;
        if (quarter > depth)
        begin
            quarter  = 2 * depth - quarter;
            negative = 1'b1;
        end
        angle    = (PI_Q30 * quarter + depth) / (2 * depth);
        angle_sq = (angle * angle) >> 30;
        term     = ONE_Q30;
        series   = longint'(ONE_Q30);
        for (k = 1; k <= 7; k++)
        begin
            term = (term * angle_sq) >> 30;
            term = term / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
                series = series - longint'(term);
            else
                series = series + longint'(term);
        end
        if (series < 0)
            series = 0;
        if (series > longint'(ONE_Q30))
            series = longint'(ONE_Q30);
        raised = negative ? longint'(ONE_Q30) - series : longint'(ONE_Q30) + series;
        scaled = ((unsigned'(raised) << LEVEL_BITS) + ONE_Q30) >> 31;
        return scaled[LEVEL_W-1:0];
    endfunction

    function automatic longint unsigned rescale(input longint unsigned value,
                                                input int from_bits, input int to_bits);
        if (to_bits >= from_bits)
            return value << (to_bits - from_bits);
        return value >> (from_bits - to_bits);
    endfunction

    function automatic longint walk_step(input logic [CFG_W-1:0] speed);
        longint num;
        longint den;
        num = 1;
        case (speed)
            SPEED_SLOW:   den = 1000;
            SPEED_MEDIUM: den = 200;
            SPEED_FAST:   den = 50;
            default:
            begin
                num = 2;
                den = 25;
            end
        endcase
        return ((num << LEVEL_BITS) + den / 2) / den;
    endfunction

    // Advances the oscillator by one song position and returns its outputs.
    function automatic lfo_sample_t next_lfo_output(input logic [POSITION_W-1:0] pos,
                                                    input logic [RANDOM_W-1:0] rnd);
        int              bits;
        longint unsigned mask;
        longint unsigned phase;
        longint unsigned last_phase;
        longint unsigned scaled;
        longint          walk;
        lfo_sample_t     result;
        bits       = POSITION_FRACTION_BITS + 4 - int'(speed_q);
        mask       = (64'd1 << bits) - 64'd1;
        phase      = 64'(pos) & mask;
        last_phase = 64'(last_position) & mask;
        result.cosine = cosine_table[(phase * COSINE_TABLE_DEPTH) >> bits];
        case (mode_q)
            MODE_COSINE:
                held_level_q = result.cosine;
            MODE_RAMP:
            begin
                scaled       = rescale(phase, bits, LEVEL_BITS);
                held_level_q = scaled[LEVEL_W-1:0];
            end
            MODE_SAMPLE:
            begin
                if (phase < last_phase)
                begin
                    scaled       = rescale(64'(rnd), RANDOM_W, LEVEL_BITS);
                    held_level_q = scaled[LEVEL_W-1:0];
                end
            end
            default:
            begin
                walk = longint'(held_level_q);
                if (rnd > RANDOM_HALF)
                    walk = walk + walk_step(speed_q);
                else
                    walk = walk - walk_step(speed_q);
                if (walk > longint'(LEVEL_ONE_L))
                    walk = 2 * longint'(LEVEL_ONE_L) - walk;
                else if (walk < 0)
                    walk = -walk;
                if (walk < 0)
                    walk = 0;
                held_level_q = walk[LEVEL_W-1:0];
            end
        endcase
        last_position = pos;
        result.level  = held_level_q;
        return result;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("lfo_level_checker: %s mismatch at %0t ns: expected %0d, got %0d",
                     what, $time, want, got);
    endtask

    initial
    begin : fill_cosine_table
        int i;
        for (i = 0; i < COSINE_TABLE_DEPTH; i++)
            cosine_table[i] = raised_cosine(i);
    end

    initial
    begin
        mismatches   = 0;
        in_flight    = 0;
        results_seen = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q        = MODE_COSINE;
            speed_q       = SPEED_RESET;
            last_position = '0;
            held_level_q  = '0;
            expected_levels.delete();
            in_flight     = 0;
        end
        else
        begin
            // Results are matched first: a result leaving at this edge can
            // never belong to an input accepted at the same edge.
            if (out_valid && out_ready)
            begin
                if (expected_levels.size() == 0)
                    note_mismatch("unrequested result (level shown)", 64'd0, 64'(level));
                else
                begin
                    oldest = expected_levels.pop_front();
                    in_flight--;
                    results_seen++;
                    if (level !== oldest.level)
                        note_mismatch("level", 64'(oldest.level), 64'(level));
                    if (cosine_level !== oldest.cosine)
                        note_mismatch("cosine_level", 64'(oldest.cosine), 64'(cosine_level));
                end
            end
            if (in_valid && in_ready)
            begin
                expected_levels.insert(expected_levels.size(),
                                       next_lfo_output(song_position, random_sample));
                in_flight++;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_WAVE_MODE:    mode_q  = cfg_data;
                    REG_SPEED_SELECT: speed_q = cfg_data;
                    default:          ;
                endcase
            end
        end
    end

endmodule

// ===== tb/tempo_synced_lfo_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tempo_synced_lfo_tb: self-checking testbench for the tempo-synced LFO
// A directed opening walks through the waveform corners, then segments of
// random song positions run under every mode and speed, with random idling
// on both channels and a few long receiver hold-offs.
// ----------------------------------------------------------------------------
module tempo_synced_lfo_tb;

    import tsl_pkg::*;

    localparam int     CLOCK_HALF_NS   = 6;
    localparam int     RESET_CYCLES    = 12;
    localparam int     RANDOM_ITEMS    = 1150;
    localparam int     HOLD_OFF_CYCLES = 80;
    // Extra wait after the in-flight count reaches zero; it covers the sampling
    // of that count in the same time step as the checker's update of it.
    localparam int     SETTLE_CYCLES   = 6;
    localparam longint CYCLE_LIMIT     = 600000;

    // Register indexes past the end of the register list; the block must
    // ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // Upward or downward bias of the random samples, which steers the walk.
    localparam int SAMPLES_EVEN = 0;
    localparam int SAMPLES_HIGH = 1;
    localparam int SAMPLES_LOW  = 2;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_write     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_W-1:0]      cfg_data      = '0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic [POSITION_W-1:0] song_position = '0;
    logic [RANDOM_W-1:0]   random_sample = '0;
    logic                  out_valid;
    logic                  out_ready     = 1'b1;
    logic [LEVEL_W-1:0]    level;
    logic [LEVEL_W-1:0]    cosine_level;

    int     mismatches;
    int     in_flight;
    int     results_seen;
    int     transactions_sent = 0;
    int     settings_tried    = 0;
    int     hold_offs         = 0;
    longint cycle_count       = 0;

    // Shared between the stimulus process and the receiver process.
    bit gaps_enabled     = 1'b1;
    bit stalls_enabled   = 1'b1;
    bit hold_off_request = 1'b0;

    tempo_synced_lfo i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .song_position (song_position),
        .random_sample (random_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .level         (level),
        .cosine_level  (cosine_level)
    );

    // The checker sees the same pins as the block and reports back the
    // number of mismatches and of transactions still in flight.
    lfo_level_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .song_position (song_position),
        .random_sample (random_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .level         (level),
        .cosine_level  (cosine_level),
        .mismatches    (mismatches),
        .in_flight     (in_flight),
        .results_seen  (results_seen)
    );

    initial
    begin
        forever #CLOCK_HALF_NS clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("tempo_synced_lfo_tb: errors");
        $finish;
    end

    // Length of an idle stretch: mostly none, often short, now and then long.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Receiver. It stalls at random while stalls are enabled, and on request
    // holds out_ready low for a long stretch so that the block's two
    // registers fill and in_ready drops while the sender keeps offering.
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                stall_left       = HOLD_OFF_CYCLES;
                hold_offs++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (stalls_enabled)
                    stall_left = idle_length();
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    // One register write. The enable is dropped at the next edge, and the task
    // returns only after the edge that samples it low, so back-to-back writes
    // never assign the enable twice in one time step.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one input transaction and waits until it is taken. The valid
    // stays high into the next transaction unless an idle gap follows.
    task automatic send_transaction(input logic [POSITION_W-1:0] pos,
                                    input logic [RANDOM_W-1:0] rnd);
        int gap;
        song_position <= pos;
        random_sample <= rnd;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        transactions_sent++;
        gap = gaps_enabled ? idle_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering and waits until every predicted result has been seen,
    // so the block is idle before the registers change.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (in_flight != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] mode, input logic [CFG_W-1:0] speed);
        settle();
        write_register(REG_WAVE_MODE, mode);
        write_register(REG_SPEED_SELECT, speed);
        settings_tried++;
    endtask

    // Random sample: a fair share of the walk's decision points (exactly one
    // half goes down, one step above it goes up) and the range ends, the
    // rest drawn with the segment's bias.
    function automatic logic [RANDOM_W-1:0] pick_sample(input int style);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            case ($urandom_range(0, 4))
                0:       return '0;
                1:       return RANDOM_HALF - RANDOM_W'(1);
                2:       return RANDOM_HALF;
                3:       return RANDOM_HALF + RANDOM_W'(1);
                default: return '1;
            endcase
        end
        if (style == SAMPLES_HIGH)
            return (pick < 85) ? RANDOM_W'($urandom_range(32769, 65535))
                               : RANDOM_W'($urandom_range(0, 32768));
        if (style == SAMPLES_LOW)
            return (pick < 85) ? RANDOM_W'($urandom_range(0, 32768))
                               : RANDOM_W'($urandom_range(32769, 65535));
        return RANDOM_W'($urandom_range(0, 65535));
    endfunction

    // Song position advance: held positions, small steps within a beat,
    // steps of up to a few beats, and longer jumps that can pass a whole period.
    function automatic int position_step();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 0;
        if (pick < 60)
            return $urandom_range(1, 64);
        if (pick < 90)
            return $urandom_range(65, 600);
        return $urandom_range(601, 5000);
    endfunction

    initial
    begin : stimulus
        int                    segment;
        int                    segment_items;
        int                    random_sent;
        int                    sample_style;
        int                    i;
        logic [CFG_W-1:0]      seg_mode;
        logic [CFG_W-1:0]      seg_speed;
        logic [POSITION_W-1:0] cursor;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening. Reset settings are cosine at the fast speed:
        // table peak at phase zero, trough at half a period, all-ones
        // position, and a point between.
        send_transaction(32'h0000_0000, 16'h0000);
        send_transaction(32'h0000_0200, 16'hFFFF);
        send_transaction(32'hFFFF_FFFF, RANDOM_HALF);
        send_transaction(32'h0000_0180, 16'h0001);

        // Writes to indexes past the register list must change nothing.
        settle();
        write_register(REG_SPARE_A, 2'd3);
        write_register(REG_SPARE_B, 2'd1);
        send_transaction(32'h0000_0200, 16'h0000);

        // Ramp at the slowest speed: top of the ramp, then a wrap to zero.
        configure(MODE_RAMP, SPEED_SLOW);
        send_transaction(32'h0000_0FFF, 16'h0000);
        send_transaction(32'h1234_5000, 16'h0000);

        // Ramp at the fastest speed, top of the short phase.
        configure(MODE_RAMP, SPEED_ULTRA);
        send_transaction(32'h0000_03FF, 16'hFFFF);

        // Sample-and-hold: a wrap takes the sample, a rising phase holds it,
        // a wrap to exactly zero takes again, and a jump whose phase rises
        // from zero does not trigger.
        configure(MODE_SAMPLE, SPEED_ULTRA);
        send_transaction(32'h0000_0100, 16'hFFFF);
        send_transaction(32'h0000_01F0, 16'h0000);
        send_transaction(32'h0000_0200, 16'h0000);
        send_transaction(32'h2000_0005, 16'hABCD);

        // Walk from full scale: a step up reflects off 1.0, and a sample of
        // exactly one half steps down.
        configure(MODE_COSINE, SPEED_ULTRA);
        send_transaction(32'h0000_0000, 16'h0000);
        configure(MODE_WALK, SPEED_ULTRA);
        send_transaction(32'h0000_0010, RANDOM_HALF + RANDOM_W'(1));
        send_transaction(32'h0000_0020, RANDOM_HALF);

        // Walk from zero: a step down reflects off 0.
        configure(MODE_COSINE, SPEED_ULTRA);
        send_transaction(32'h0000_0100, 16'h0000);
        configure(MODE_WALK, SPEED_SLOW);
        send_transaction(32'h0000_0000, 16'h0000);
        send_transaction(32'h0000_0000, 16'hFFFF);
        configure(MODE_WALK, SPEED_MEDIUM);
        send_transaction(32'h0000_0040, RANDOM_HALF - RANDOM_W'(1));

        // Random segments. The first sixteen sweep every mode and speed
        // pair; later ones pick settings at random. Between segments the
        // sender pauses until every result is back, since the registers
        // change only while the block is idle.
        segment     = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            if (segment < 16)
            begin
                seg_mode  = CFG_W'(segment % 4);
                seg_speed = CFG_W'(segment / 4);
                write_register(REG_WAVE_MODE, seg_mode);
                write_register(REG_SPEED_SELECT, seg_speed);
            end
            else
            begin
                seg_mode  = CFG_W'($urandom_range(0, 3));
                seg_speed = CFG_W'($urandom_range(0, 3));
                case ($urandom_range(0, 6))
                    0:       write_register(REG_WAVE_MODE, seg_mode);
                    1:       write_register(REG_SPEED_SELECT, seg_speed);
                    default:
                    begin
                        write_register(REG_WAVE_MODE, seg_mode);
                        write_register(REG_SPEED_SELECT, seg_speed);
                    end
                endcase
                if ($urandom_range(0, 4) == 0)
                    write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                                   CFG_W'($urandom_range(0, 3)));
            end
            settings_tried++;

            gaps_enabled   = ($urandom_range(0, 3) != 0);
            stalls_enabled = ($urandom_range(0, 3) != 0);
            // Now and then the receiver holds off for a long stretch while
            // the sender pushes without gaps, so the block backs up.
            if (segment % 7 == 3)
            begin
                gaps_enabled     = 1'b0;
                hold_off_request = 1'b1;
            end

            sample_style  = $urandom_range(SAMPLES_EVEN, SAMPLES_LOW);
            segment_items = $urandom_range(20, 80);
            if ($urandom_range(0, 9) == 0)
                cursor = 32'hFFFF_FF00 + $urandom_range(0, 255);
            else
                cursor = $urandom;

            // Mostly a song running forward with random step sizes, so the
            // phase wraps in order; a share of unrelated positions as noise.
            for (i = 0; i < segment_items && random_sent < RANDOM_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) < 15)
                    send_transaction($urandom, RANDOM_W'($urandom));
                else
                begin
                    cursor = cursor + POSITION_W'(position_step());
                    send_transaction(cursor, pick_sample(sample_style));
                end
                random_sent++;
            end
            segment++;
        end

        settle();

        $display("summary: %0d transactions under %0d register settings, %0d results compared",
                 transactions_sent, settings_tried, results_seen);
        $display("summary: %0d long receiver hold-offs, %0d clock cycles",
                 hold_offs, cycle_count);
        if (mismatches == 0 && in_flight == 0)
            $display("tempo_synced_lfo_tb: clean");
        else
            $display("tempo_synced_lfo_tb: errors");
        $finish;
    end

endmodule

// ===== tempo_synced_lfo.f =====
rtl/tsl_pkg.sv
rtl/tsl_phase.sv
rtl/tsl_level.sv
rtl/tempo_synced_lfo.sv
tb/lfo_level_checker.sv
tb/tempo_synced_lfo_tb.sv
